/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point engine checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/ecpsm_pkg.sv */
// ----------------------------------------------------------------------------
// ecpsm_pkg
// Shared types and constants of the elliptic-curve point engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecpsm_pkg;

    localparam int FIELD_BITS_DEF  = 16;
    localparam int SCALAR_BITS_DEF = 16;

    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_CURVE_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS = 2'd1;

    localparam logic [CFG_W-1:0] CURVE_A_RESET = 16'd497;
    localparam logic [CFG_W-1:0] MODULUS_RESET = 16'd9739;
    localparam int               MIN_MODULUS   = 3;
    localparam int               THREE         = 3;

    localparam int COORD_W   = 16;
    localparam int IN_DATA_W = 88;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

endpackage

/* rtl/ec_point_scalar_multiply_core.sv */
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply_core
// Affine short Weierstrass point engine: scalar multiply and point add.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tuser: mode; tdata: scalar, first point, second point
//  m_axis    | out       | tdata: result_x, result_y, result_inf
//  cfg       | in        | register index and write data (curve_a, modulus)
//
// One request at a time; s_axis_tready is low from acceptance until the result
// is loaded. Each point add runs through the shared field unit, which also reduces
// the inputs; the inverse runs Euclid quotient steps, each a divide, a multiply
// and a subtract on that unit.
// Scalar mode takes up to 2*SCALAR_BITS point adds; add mode takes one.
// Reset restores curve_a 497 and modulus 9739.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ec_point_scalar_multiply_core
    import ecpsm_pkg::*;
#(
    parameter int FIELD_BITS  = FIELD_BITS_DEF,
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // scalar, first_x, first_y, first_inf, second_x, second_y, second_inf
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_x, result_y, result_inf
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int W   = FIELD_BITS;
    localparam int S   = SCALAR_BITS;
    localparam int IW  = $clog2(SCALAR_BITS + 1);
    localparam int KIW = $clog2(SCALAR_BITS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RED_A, ST_RED_PX, ST_RED_PY, ST_RED_QX, ST_RED_QY,
        ST_DISPATCH, ST_LOOP, ST_DBL_CALL, ST_ADD_ENTRY, ST_ADD_NEG,
        ST_DBL_SQ, ST_DBL_MUL3, ST_DBL_NUM, ST_DBL_DEN, ST_GEN_NUM, ST_GEN_DEN,
        ST_INV_INIT, ST_INV_CHECK, ST_INV_DIV, ST_INV_MUL, ST_INV_SUB,
        ST_LAM, ST_X_SQ, ST_X_SUB1, ST_X_SUB2, ST_Y_SUB, ST_Y_MUL, ST_Y_SUB2,
        ST_RET, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CALL_PAIR,
        CALL_ACC,
        CALL_DBL
    } caller_t;

    state_t  state_reg;
    caller_t caller_reg;
    logic    issued_reg;

    logic [CFG_W-1:0] curve_a_reg;
    logic [CFG_W-1:0] modulus_reg;

    logic         mode_reg;
    logic [S-1:0] k_reg;
    logic [IW-1:0] i_reg;
    logic [W-1:0] m_reg, a_reg;
    logic [W-1:0] px_reg, py_reg, qx_reg, qy_reg, rx_reg, ry_reg;
    logic         pinf_reg, qinf_reg, rinf_reg;
    logic [W-1:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic         uinf_reg, vinf_reg, winf_reg;
    logic [W-1:0] t_reg, num_reg, den_reg, lam_reg;
    logic [W-1:0] rp_reg, rc_reg, sp_reg, sc_reg, q_reg, rn_reg;

    logic                   m_valid_reg;
    logic [COORD_W-1:0]     out_x_reg, out_y_reg;
    logic                   out_inf_reg;

    alu_ctrl_t    alu_ctrl;
    logic         arith;
    alu_op_t      op;
    logic [W-1:0] ax, ay;
    logic         alu_done;
    logic [W-1:0] alu_res, alu_rem;
    logic [W-1:0] three_w, q_red;
    logic [W-1:0] mod_in;

    assign mod_in  = W'(modulus_reg);
    assign three_w = (m_reg == W'(THREE)) ? '0 : W'(THREE);
    assign q_red   = (q_reg >= m_reg) ? q_reg - m_reg : q_reg;

    always_comb
    begin
        arith = 1'b1;
        op    = ALU_ADD;
        ax    = '0;
        ay    = '0;
        unique case (state_reg)
            ST_RED_A:    begin op = ALU_DIV; ax = a_reg;   ay = m_reg;   end
            ST_RED_PX:   begin op = ALU_DIV; ax = px_reg;  ay = m_reg;   end
            ST_RED_PY:   begin op = ALU_DIV; ax = py_reg;  ay = m_reg;   end
            ST_RED_QX:   begin op = ALU_DIV; ax = qx_reg;  ay = m_reg;   end
            ST_RED_QY:   begin op = ALU_DIV; ax = qy_reg;  ay = m_reg;   end
            ST_ADD_NEG:  begin op = ALU_ADD; ax = uy_reg;  ay = vy_reg;  end
            ST_DBL_SQ:   begin op = ALU_MUL; ax = ux_reg;  ay = ux_reg;  end
            ST_DBL_MUL3: begin op = ALU_MUL; ax = three_w; ay = t_reg;   end
            ST_DBL_NUM:  begin op = ALU_ADD; ax = t_reg;   ay = a_reg;   end
            ST_DBL_DEN:  begin op = ALU_ADD; ax = uy_reg;  ay = uy_reg;  end
            ST_GEN_NUM:  begin op = ALU_SUB; ax = vy_reg;  ay = uy_reg;  end
            ST_GEN_DEN:  begin op = ALU_SUB; ax = vx_reg;  ay = ux_reg;  end
            ST_INV_DIV:  begin op = ALU_DIV; ax = rp_reg;  ay = rc_reg;  end
            ST_INV_MUL:  begin op = ALU_MUL; ax = q_red;   ay = sc_reg;  end
            ST_INV_SUB:  begin op = ALU_SUB; ax = sp_reg;  ay = t_reg;   end
            ST_LAM:      begin op = ALU_MUL; ax = num_reg; ay = sp_reg;  end
            ST_X_SQ:     begin op = ALU_MUL; ax = lam_reg; ay = lam_reg; end
            ST_X_SUB1:   begin op = ALU_SUB; ax = t_reg;   ay = ux_reg;  end
            ST_X_SUB2:   begin op = ALU_SUB; ax = t_reg;   ay = vx_reg;  end
            ST_Y_SUB:    begin op = ALU_SUB; ax = ux_reg;  ay = wx_reg;  end
            ST_Y_MUL:    begin op = ALU_MUL; ax = lam_reg; ay = t_reg;   end
            ST_Y_SUB2:   begin op = ALU_SUB; ax = t_reg;   ay = uy_reg;  end
            default:     arith = 1'b0;
        endcase
        alu_ctrl.start = arith && !issued_reg;
        alu_ctrl.op    = op;
    end

    ecpsm_alu #(
        .FIELD_BITS (FIELD_BITS)
    ) u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (alu_ctrl),
        .opx     (ax),
        .opy     (ay),
        .modulus (m_reg),
        .done    (alu_done),
        .res     (alu_res),
        .rem     (alu_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_a_reg <= CURVE_A_RESET;
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_CURVE_A)
            begin
                curve_a_reg <= cfg_data;
            end
            else if (cfg_index == REG_MODULUS)
            begin
                modulus_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            caller_reg  <= CALL_PAIR;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (arith)
            begin
                if (alu_done)
                begin
                    issued_reg <= 1'b0;
                end
                else
                begin
                    issued_reg <= 1'b1;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        mode_reg <= s_axis_tuser;
                        k_reg    <= S'(s_axis_tdata[15:0]);
                        px_reg   <= W'(s_axis_tdata[31:16]);
                        py_reg   <= W'(s_axis_tdata[47:32]);
                        pinf_reg <= s_axis_tdata[48];
                        qx_reg   <= W'(s_axis_tdata[64:49]);
                        qy_reg   <= W'(s_axis_tdata[80:65]);
                        qinf_reg <= s_axis_tdata[81];
                        a_reg    <= W'(curve_a_reg);
                        m_reg    <= mod_in;
                        rinf_reg <= 1'b1;
                        rx_reg   <= '0;
                        ry_reg   <= '0;
                        state_reg <= (mod_in < W'(MIN_MODULUS)) ? ST_DONE : ST_RED_A;
                    end
                end
                ST_RED_A:  if (alu_done) begin a_reg  <= alu_rem; state_reg <= ST_RED_PX; end
                ST_RED_PX: if (alu_done) begin px_reg <= alu_rem; state_reg <= ST_RED_PY; end
                ST_RED_PY: if (alu_done) begin py_reg <= alu_rem; state_reg <= ST_RED_QX; end
                ST_RED_QX: if (alu_done) begin qx_reg <= alu_rem; state_reg <= ST_RED_QY; end
                ST_RED_QY: if (alu_done) begin qy_reg <= alu_rem; state_reg <= ST_DISPATCH; end
                ST_DISPATCH:
                begin
                    if (mode_reg)
                    begin
                        ux_reg <= px_reg; uy_reg <= py_reg; uinf_reg <= pinf_reg;
                        vx_reg <= qx_reg; vy_reg <= qy_reg; vinf_reg <= qinf_reg;
                        caller_reg <= CALL_PAIR;
                        state_reg  <= ST_ADD_ENTRY;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_LOOP;
                    end
                end
                ST_LOOP:
                begin
                    if (i_reg == IW'(S))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (k_reg[i_reg[KIW-1:0]])
                    begin
                        ux_reg <= rx_reg; uy_reg <= ry_reg; uinf_reg <= rinf_reg;
                        vx_reg <= px_reg; vy_reg <= py_reg; vinf_reg <= pinf_reg;
                        caller_reg <= CALL_ACC;
                        state_reg  <= ST_ADD_ENTRY;
                    end
                    else
                    begin
                        state_reg <= ST_DBL_CALL;
                    end
                end
                ST_DBL_CALL:
                begin
                    ux_reg <= px_reg; uy_reg <= py_reg; uinf_reg <= pinf_reg;
                    vx_reg <= px_reg; vy_reg <= py_reg; vinf_reg <= pinf_reg;
                    caller_reg <= CALL_DBL;
                    state_reg  <= ST_ADD_ENTRY;
                end
                ST_ADD_ENTRY:
                begin
                    priority if (uinf_reg)
                    begin
                        wx_reg <= vx_reg; wy_reg <= vy_reg; winf_reg <= vinf_reg;
                        state_reg <= ST_RET;
                    end
                    else if (vinf_reg)
                    begin
                        wx_reg <= ux_reg; wy_reg <= uy_reg; winf_reg <= 1'b0;
                        state_reg <= ST_RET;
                    end
                    else if (ux_reg == vx_reg)
                    begin
                        state_reg <= ST_ADD_NEG;
                    end
                    else
                    begin
                        state_reg <= ST_GEN_NUM;
                    end
                end
                ST_ADD_NEG:
                begin
                    if (alu_done)
                    begin
                        priority if (alu_res == '0)
                        begin
                            wx_reg <= '0; wy_reg <= '0; winf_reg <= 1'b1;
                            state_reg <= ST_RET;
                        end
                        else if (uy_reg == vy_reg)
                        begin
                            state_reg <= ST_DBL_SQ;
                        end
                        else
                        begin
                            state_reg <= ST_GEN_NUM;
                        end
                    end
                end
                ST_DBL_SQ:   if (alu_done) begin t_reg <= alu_res;   state_reg <= ST_DBL_MUL3; end
                ST_DBL_MUL3: if (alu_done) begin t_reg <= alu_res;   state_reg <= ST_DBL_NUM; end
                ST_DBL_NUM:  if (alu_done) begin num_reg <= alu_res; state_reg <= ST_DBL_DEN; end
                ST_DBL_DEN:  if (alu_done) begin den_reg <= alu_res; state_reg <= ST_INV_INIT; end
                ST_GEN_NUM:  if (alu_done) begin num_reg <= alu_res; state_reg <= ST_GEN_DEN; end
                ST_GEN_DEN:  if (alu_done) begin den_reg <= alu_res; state_reg <= ST_INV_INIT; end
                ST_INV_INIT:
                begin
                    rp_reg <= den_reg;
                    rc_reg <= m_reg;
                    sp_reg <= W'(1);
                    sc_reg <= '0;
                    state_reg <= ST_INV_CHECK;
                end
                ST_INV_CHECK:
                begin
                    state_reg <= (rc_reg == '0) ? ST_LAM : ST_INV_DIV;
                end
                ST_INV_DIV:
                begin
                    if (alu_done)
                    begin
                        q_reg  <= alu_res;
                        rn_reg <= alu_rem;
                        state_reg <= ST_INV_MUL;
                    end
                end
                ST_INV_MUL:  if (alu_done) begin t_reg <= alu_res; state_reg <= ST_INV_SUB; end
                ST_INV_SUB:
                begin
                    if (alu_done)
                    begin
                        rp_reg <= rc_reg;
                        rc_reg <= rn_reg;
                        sp_reg <= sc_reg;
                        sc_reg <= alu_res;
                        state_reg <= ST_INV_CHECK;
                    end
                end
                ST_LAM:    if (alu_done) begin lam_reg <= alu_res; state_reg <= ST_X_SQ; end
                ST_X_SQ:   if (alu_done) begin t_reg <= alu_res;   state_reg <= ST_X_SUB1; end
                ST_X_SUB1: if (alu_done) begin t_reg <= alu_res;   state_reg <= ST_X_SUB2; end
                ST_X_SUB2: if (alu_done) begin wx_reg <= alu_res;  state_reg <= ST_Y_SUB; end
                ST_Y_SUB:  if (alu_done) begin t_reg <= alu_res;   state_reg <= ST_Y_MUL; end
                ST_Y_MUL:  if (alu_done) begin t_reg <= alu_res;   state_reg <= ST_Y_SUB2; end
                ST_Y_SUB2:
                begin
                    if (alu_done)
                    begin
                        wy_reg    <= alu_res;
                        winf_reg  <= 1'b0;
                        state_reg <= ST_RET;
                    end
                end
                ST_RET:
                begin
                    unique case (caller_reg)
                        CALL_ACC:
                        begin
                            rx_reg <= wx_reg; ry_reg <= wy_reg; rinf_reg <= winf_reg;
                            state_reg <= ST_DBL_CALL;
                        end
                        CALL_DBL:
                        begin
                            px_reg <= wx_reg; py_reg <= wy_reg; pinf_reg <= winf_reg;
                            i_reg  <= i_reg + 1'b1;
                            state_reg <= ST_LOOP;
                        end
                        default:
                        begin
                            rx_reg <= wx_reg; ry_reg <= wy_reg; rinf_reg <= winf_reg;
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        out_inf_reg <= rinf_reg;
                        out_x_reg   <= rinf_reg ? '0 : COORD_W'(rx_reg);
                        out_y_reg   <= rinf_reg ? '0 : COORD_W'(ry_reg);
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, out_inf_reg, out_y_reg, out_x_reg};

endmodule

/* rtl/ecpsm_alu.sv */
// ----------------------------------------------------------------------------
// ecpsm_alu
// Shared field unit: modular add and subtract with a registered result, modular multiply
// by double-and-add and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecpsm_alu
    import ecpsm_pkg::*;
#(
    parameter int FIELD_BITS = FIELD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  alu_ctrl_t             ctrl,
    input  logic [FIELD_BITS-1:0] opx,
    input  logic [FIELD_BITS-1:0] opy,
    input  logic [FIELD_BITS-1:0] modulus,
    output logic                  done,
    output logic [FIELD_BITS-1:0] res,
    output logic [FIELD_BITS-1:0] rem
);

    localparam int W  = FIELD_BITS;
    localparam int CW = $clog2(FIELD_BITS);

    logic          busy_reg;
    logic          done_reg;
    alu_op_t       op_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  rem_reg;

    logic [W-1:0]  mul_a1;
    logic [W-1:0]  mul_next;
    logic [W:0]    div_r1;
    logic          div_ge;

    function automatic logic [W-1:0] fadd(input logic [W-1:0] u, input logic [W-1:0] v,
                                          input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, v};
        return (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : W'(s);
    endfunction

    function automatic logic [W-1:0] fsub(input logic [W-1:0] u, input logic [W-1:0] v,
                                          input logic [W-1:0] m);
        return (u >= v) ? u - v : u + (m - v);
    endfunction

    always_comb
    begin
        mul_a1   = fadd(acc_reg, acc_reg, modulus);
        mul_next = y_reg[W-1] ? fadd(mul_a1, x_reg, modulus) : mul_a1;
        div_r1   = {rem_reg, y_reg[W-1]};
        div_ge   = (div_r1 >= {1'b0, x_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_ADD;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (op_reg == ALU_MUL)
                begin
                    acc_reg <= mul_next;
                    y_reg   <= {y_reg[W-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= div_ge ? W'(div_r1 - {1'b0, x_reg}) : W'(div_r1);
                    y_reg   <= {y_reg[W-2:0], div_ge};
                end
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else if (ctrl.start)
            begin
                op_reg <= ctrl.op;
                unique case (ctrl.op)
                    ALU_ADD:
                    begin
                        acc_reg  <= fadd(opx, opy, modulus);
                        done_reg <= 1'b1;
                    end
                    ALU_SUB:
                    begin
                        acc_reg  <= fsub(opx, opy, modulus);
                        done_reg <= 1'b1;
                    end
                    ALU_MUL:
                    begin
                        acc_reg  <= '0;
                        x_reg    <= opx;
                        y_reg    <= opy;
                        cnt_reg  <= CW'(W - 1);
                        busy_reg <= 1'b1;
                    end
                    ALU_DIV:
                    begin
                        rem_reg  <= '0;
                        y_reg    <= opx;
                        x_reg    <= opy;
                        cnt_reg  <= CW'(W - 1);
                        busy_reg <= 1'b1;
                    end
                    default:
                    begin
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == ALU_DIV) ? y_reg : acc_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/ecpsm_checker.sv */
// ----------------------------------------------------------------------------
// ecpsm_checker
// Port-level checks of the point engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ecpsm_checker
    import ecpsm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_SAME(a_inf_zero, clk, rst_n, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0)

endmodule

bind ec_point_scalar_multiply_core ecpsm_checker u_ecpsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
